### hdl/aesr_pkg.sv
// ----------------------------------------------------------------------------
// aesr_pkg: shared types and tables for the keyless AES round
// Payload structs for both channels, the AES S-box and GF(2^8) helpers.
// ----------------------------------------------------------------------------
package aesr_pkg;

  localparam int unsigned BlockBytes = 16;
  localparam int unsigned CountW     = 5;

  typedef struct packed {
    logic [63:0]       block_high;
    logic [63:0]       block_low;
    logic [CountW-1:0] byte_count;
  } aesr_in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } aesr_out_t;

  // Reduction term of the field polynomial x^8 + x^4 + x^3 + x + 1.
  localparam logic [7:0] GfReduce = 8'h1b;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] sbox(input logic [7:0] b);
    return SBOX[b];
  endfunction

  // Multiply by x modulo the field polynomial.
  function automatic logic [7:0] xtime(input logic [7:0] v);
    return v[7] ? ({v[6:0], 1'b0} ^ GfReduce) : {v[6:0], 1'b0};
  endfunction

endpackage

### hdl/aes_round_without_key.sv
// ----------------------------------------------------------------------------
// aes_round_without_key: padded keyless AES round, one block per cycle while out_ready is high
// Input register, combinational round, result register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready/in_data carries a 16-byte block and a
//   count of valid bytes; bytes past the count are PKCS#7 padded. Result
//   channel out_valid/out_ready/out_data carries the 16 bytes after SubBytes,
//   ShiftRows and MixColumns (no round key).
//   Path: an accepted transaction sits in the input register, then moves
//   into the result register, raising out_valid, once that register is
//   empty or its result is being taken.
//   Throughput: one transaction per cycle while out_ready stays high; the
//   input register empties into the result register in the same cycle that
//   it is refilled, so in_ready stays high.
//   Stall: with out_ready low the result holds; one more transaction can be
//   taken into the input register, after which in_ready drops until the
//   result is taken.
//   Reset: rst_n (synchronous, active low) empties both registers; no
//   transaction is in flight afterward.
// ----------------------------------------------------------------------------
module aes_round_without_key (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  aesr_pkg::aesr_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output aesr_pkg::aesr_out_t  out_data
);

  logic                s1_valid_r;
  logic                s1_valid_nxt;
  aesr_pkg::aesr_in_t  s1_data_r;
  logic                out_valid_r;
  logic                out_valid_nxt;
  aesr_pkg::aesr_out_t out_data_r;
  aesr_pkg::aesr_out_t round_res;
  logic                s1_adv;
  logic                in_take;

  aesr_round u_round (
    .in_item  (s1_data_r),
    .out_item (round_res)
  );

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt  = in_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_adv ? 1'b1 : ((out_valid_r && out_ready) ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: load on transfer, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= round_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hdl/aesr_round.sv
// ----------------------------------------------------------------------------
// aesr_round: combinational keyless AES round
// Pads the block, then applies SubBytes, ShiftRows and MixColumns.
// ----------------------------------------------------------------------------
module aesr_round (
  input  aesr_pkg::aesr_in_t  in_item,
  output aesr_pkg::aesr_out_t out_item
);

  logic [aesr_pkg::CountW-1:0] cnt;
  logic [7:0]                  pad;
  logic [127:0]                blk_flat;
  logic [7:0]                  blk [16];
  logic [7:0]                  sb  [16];
  logic [7:0]                  sr  [16];
  logic [7:0]                  mc  [16];

  // Saturate the count at a full block; zero gives a full pad block.
  assign cnt      = (in_item.byte_count > aesr_pkg::CountW'(aesr_pkg::BlockBytes))
                    ? aesr_pkg::CountW'(aesr_pkg::BlockBytes) : in_item.byte_count;
  assign pad      = 8'(aesr_pkg::BlockBytes) - {3'b000, cnt};
  assign blk_flat = {in_item.block_high, in_item.block_low};

  // Byte index i = 4*column + row throughout.
  for (genvar i = 0; i < 16; i++) begin : g_sub
    assign blk[i] = (aesr_pkg::CountW'(i) < cnt) ? blk_flat[127-8*i -: 8] : pad;
    assign sb[i]  = aesr_pkg::sbox(blk[i]);
  end

  for (genvar c = 0; c < 4; c++) begin : g_col
    for (genvar r = 0; r < 4; r++) begin : g_row
      assign sr[4*c+r] = sb[4*((c+r)%4)+r];
    end

    assign mc[4*c+0] = aesr_pkg::xtime(sr[4*c+0]) ^ aesr_pkg::xtime(sr[4*c+1]) ^ sr[4*c+1]
                       ^ sr[4*c+2] ^ sr[4*c+3];
    assign mc[4*c+1] = sr[4*c+0] ^ aesr_pkg::xtime(sr[4*c+1]) ^ aesr_pkg::xtime(sr[4*c+2])
                       ^ sr[4*c+2] ^ sr[4*c+3];
    assign mc[4*c+2] = sr[4*c+0] ^ sr[4*c+1] ^ aesr_pkg::xtime(sr[4*c+2])
                       ^ aesr_pkg::xtime(sr[4*c+3]) ^ sr[4*c+3];
    assign mc[4*c+3] = aesr_pkg::xtime(sr[4*c+0]) ^ sr[4*c+0] ^ sr[4*c+1] ^ sr[4*c+2]
                       ^ aesr_pkg::xtime(sr[4*c+3]);
  end

  for (genvar i = 0; i < 8; i++) begin : g_out
    assign out_item.result_high[63-8*i -: 8] = mc[i];
    assign out_item.result_low[63-8*i -: 8]  = mc[i+8];
  end

endmodule

### hdl/aesr_checker.sv
// ----------------------------------------------------------------------------
// aesr_checker: port-level checks for aes_round_without_key
// Watches both channels over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module aesr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input aesr_pkg::aesr_out_t out_data
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // With the result side empty, the input side must be ready to take a transaction.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // A fresh result follows an accepted transaction.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without an accepted transaction");

endmodule

bind aes_round_without_key aesr_checker u_aesr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the keyless AES round
// Drives padded 16-byte blocks over the input channel, with random idle gaps
// and result back-pressure. Each result is compared with a model of padding,
// SubBytes, ShiftRows and MixColumns, or with a typed-in known answer.
// ----------------------------------------------------------------------------
module tb;

  localparam int RandomBlocks = 1000;
  localparam int IdleLimit    = 2000;
  localparam int ReportMax    = 10;

  typedef struct {
    aesr_pkg::aesr_in_t  stim;
    bit                  known;
    aesr_pkg::aesr_out_t want;
  } blk_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  aesr_pkg::aesr_in_t  in_data;
  logic                out_valid;
  logic                out_ready = 1'b0;
  aesr_pkg::aesr_out_t out_data;

  logic [7:0]          sbox_lut [256];
  blk_row_t            sent_rows [$];
  aesr_pkg::aesr_out_t pending_rounds [$];
  blk_row_t            dir_rows [$];
  int                  n_bad = 0;
  int                  idle_cycles = 0;
  int                  rdy_hold = 0;

  aes_round_without_key u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [7:0] gf_x2(input logic [7:0] v);
    return v[7] ? ({v[6:0], 1'b0} ^ 8'h1b) : {v[6:0], 1'b0};
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) p ^= a;
      a = gf_x2(a);
    end
    return p;
  endfunction

  // Build the S-box from the field inverse and the affine map.
  initial begin
    logic [7:0] inv;
    for (int v = 0; v < 256; v++) begin
      inv = 8'h01;
      repeat (254) inv = gf_mul(inv, 8'(v));
      sbox_lut[v] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^
                    {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    end
  end

  function automatic aesr_pkg::aesr_out_t mix_round(input aesr_pkg::aesr_in_t t);
    logic [127:0] blk;
    logic [127:0] res;
    logic [7:0]   a [4];
    logic [7:0]   b;
    int           cnt;
    int           idx;
    blk = {t.block_high, t.block_low};
    cnt = (t.byte_count > 16) ? 16 : int'(t.byte_count);
    for (int c = 0; c < 4; c++) begin
      // Gather the column after ShiftRows, padding and substituting on the way.
      for (int r = 0; r < 4; r++) begin
        idx  = 4 * ((c + r) % 4) + r;
        b    = (idx < cnt) ? blk[127 - 8 * idx -: 8] : 8'(16 - cnt);
        a[r] = sbox_lut[b];
      end
      res[127 - 32 * c      -: 8] = gf_x2(a[0]) ^ gf_x2(a[1]) ^ a[1] ^ a[2] ^ a[3];
      res[127 - 32 * c - 8  -: 8] = a[0] ^ gf_x2(a[1]) ^ gf_x2(a[2]) ^ a[2] ^ a[3];
      res[127 - 32 * c - 16 -: 8] = a[0] ^ a[1] ^ gf_x2(a[2]) ^ gf_x2(a[3]) ^ a[3];
      res[127 - 32 * c - 24 -: 8] = gf_x2(a[0]) ^ a[0] ^ a[1] ^ a[2] ^ gf_x2(a[3]);
    end
    return res;
  endfunction

  function automatic blk_row_t mk_row(input logic [63:0] hi, input logic [63:0] lo,
                                      input logic [4:0] cnt, input bit known,
                                      input logic [127:0] want);
    blk_row_t row;
    row.stim  = {hi, lo, cnt};
    row.known = known;
    row.want  = want;
    return row;
  endfunction

  task automatic queue_row(input blk_row_t row);
    dir_rows = {dir_rows, row};
  endtask

  function automatic blk_row_t rand_row();
    blk_row_t   row;
    logic [7:0] fill;
    int         pick;
    row.known = 1'b0;
    row.want  = '0;
    fill = 8'($urandom);
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      row.stim.block_high = {8{fill}};
      row.stim.block_low  = {8{fill}};
    end else begin
      row.stim.block_high = {$urandom, $urandom};
      row.stim.block_low  = {$urandom, $urandom};
    end
    pick = $urandom_range(0, 19);
    if (pick < 14)      row.stim.byte_count = 5'($urandom_range(1, 16));
    else if (pick < 16) row.stim.byte_count = 5'd16;
    else if (pick < 18) row.stim.byte_count = 5'd0;
    else                row.stim.byte_count = 5'($urandom_range(17, 31));
    return row;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  task automatic note_bad(input string what, input logic [63:0] exp_v,
                          input logic [63:0] got_v);
    if (n_bad < ReportMax)
      $display("mismatch %s: expected %h got %h", what, exp_v, got_v);
    n_bad++;
  endtask

  // Result back-pressure: short toggles, long stalls and long open stretches.
  always @(posedge clk) begin
    int r;
    if (rdy_hold > 0) begin
      rdy_hold <= rdy_hold - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_ready <= 1'b1;
        rdy_hold  <= $urandom_range(0, 3);
      end else if (r < 80) begin
        out_ready <= 1'b0;
        rdy_hold  <= $urandom_range(0, 2);
      end else if (r < 92) begin
        out_ready <= 1'b1;
        rdy_hold  <= $urandom_range(20, 60);
      end else begin
        out_ready <= 1'b0;
        rdy_hold  <= $urandom_range(10, 40);
      end
    end
  end

  // Track accepted transactions, check results, and watch for a hang.
  always @(posedge clk) begin
    blk_row_t            row;
    aesr_pkg::aesr_out_t exp_r;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
      if (in_valid && in_ready) begin
        row = sent_rows.pop_front();
        pending_rounds = {pending_rounds, row.known ? row.want : mix_round(in_data)};
      end
      if (out_valid && out_ready) begin
        if (pending_rounds.size() == 0) begin
          note_bad("unexpected result_high", '0, out_data.result_high);
        end else begin
          exp_r = pending_rounds.pop_front();
          if (out_data.result_high !== exp_r.result_high)
            note_bad("result_high", exp_r.result_high, out_data.result_high);
          if (out_data.result_low !== exp_r.result_low)
            note_bad("result_low", exp_r.result_low, out_data.result_low);
        end
      end
    end
  end

  initial begin
    blk_row_t row;
    int       n_items;
    int       gap;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;

    // Uniform bytes pass MixColumns unchanged, so those answers are the S-box entry.
    queue_row(mk_row('0, '0, 5'd16, 1'b1, {16{8'h63}}));
    queue_row(mk_row('1, '1, 5'd16, 1'b1, {16{8'h16}}));
    queue_row(mk_row('0, '0, 5'd0, 1'b1, {16{8'hca}}));
    queue_row(mk_row('1, '1, 5'd0, 1'b1, {16{8'hca}}));
    queue_row(mk_row('0, '0, 5'd31, 1'b1, {16{8'h63}}));
    queue_row(mk_row({8{8'h01}}, {8{8'h01}}, 5'd15, 1'b1, {16{8'h7c}}));
    queue_row(mk_row({8{8'h0f}}, {8{8'h0f}}, 5'd1, 1'b1, {16{8'h76}}));
    queue_row(mk_row(64'h193de3bea0f4e22b, 64'h9ac68d2ae9f84808, 5'd16, 1'b0, '0));
    queue_row(mk_row(64'h193de3bea0f4e22b, 64'h9ac68d2ae9f84808, 5'd17, 1'b0, '0));
    queue_row(mk_row('1, '1, 5'd1, 1'b0, '0));
    queue_row(mk_row('1, '1, 5'd8, 1'b0, '0));
    queue_row(mk_row('1, '1, 5'd9, 1'b0, '0));
    queue_row(mk_row('1, '1, 5'd15, 1'b0, '0));
    queue_row(mk_row(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd16, 1'b0, '0));
    queue_row(mk_row(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd7, 1'b0, '0));
    queue_row(mk_row(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 5'd16, 1'b0, '0));
    queue_row(mk_row(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 5'd12, 1'b0, '0));
    queue_row(mk_row(64'h8000000000000001, 64'h0000000000000080, 5'd16, 1'b0, '0));
    queue_row(mk_row(64'h0011223344556677, 64'h8899aabbccddeeff, 5'd20, 1'b0, '0));
    queue_row(mk_row(64'h0011223344556677, 64'h8899aabbccddeeff, 5'd2, 1'b0, '0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    n_items = dir_rows.size() + RandomBlocks;
    for (int k = 0; k < n_items; k++) begin
      if (k < dir_rows.size()) row = dir_rows[k];
      else row = rand_row();
      // Every fourth stretch of forty blocks goes back to back.
      gap = (((k / 40) % 4) == 1) ? 0 : gap_len();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      sent_rows = {sent_rows, row};
      in_valid <= 1'b1;
      in_data  <= row.stim;
      do @(posedge clk); while (!in_ready);
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (pending_rounds.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (n_bad == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/aesr_pkg.sv
hdl/aesr_round.sv
hdl/aes_round_without_key.sv
hdl/aesr_checker.sv
tb/tb.sv
